FILE: rtl/sfjc_pkg.sv
// Shared constants and types for the skeletal frame joint composer.
// Used by skeletal_frame_joint_composer_unit; no dependencies.
`timescale 1ns / 1ps

package sfjc_pkg;

    localparam int MAX_JOINTS = 256;
    localparam int MAX_VALUES = 2048;

    // address widths of the two stores and width of the joint counter
    localparam int VAW   = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int JAW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_JOINTS + 1);

    localparam logic [17:0] ONE_Q16 = 18'd65536;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_JOINT = 2'd1,
        OP_FRAME = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PARENT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FETCH = 11'b00000000010,
        S_FWAIT = 11'b00000000100,
        S_MAC   = 11'b00000001000,
        S_SQRT  = 11'b00000010000,
        S_POSTW = 11'b00000100000,
        S_MAX   = 11'b00001000000,
        S_SHIFT = 11'b00010000000,
        S_DLOAD = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } fsm_t;

    // where a finished multiply-accumulate chain lands
    typedef enum logic [2:0] {
        D_SUM  = 3'd0,
        D_T    = 3'd1,
        D_RA   = 3'd2,
        D_RB   = 3'd3,
        D_Q    = 3'd4,
        D_NSUM = 3'd5
    } dest_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [17:0] q_x;
        logic signed [17:0] q_y;
        logic signed [17:0] q_z;
        logic signed [17:0] q_w;
    } joint_row_t;

endpackage

FILE: rtl/skeletal_frame_joint_composer_unit.sv
// Skeletal frame joint composer: value store, joint store and the shared
// multiply-accumulate / square root / divide sequencer. Depends on sfjc_pkg.
`timescale 1ns / 1ps

//  channel | dir | tdata                           | tuser  | accept
//  s_      | in  | value_index .. parent_index     | opcode | s_tvalid & s_tready
//  m_      | out | joint_number, pos xyz, quat xyzw| status | m_tvalid & m_tready
//
//  Load and new-frame words are taken in S_IDLE. A joint fetches its animated
//  components from the value store, then runs multiply-accumulate steps (a
//  multiply, then an accumulate) on the one multiplier, square roots, normalize
//  shifts and four divides; a root skips the rotate/product steps and w skips
//  its square root when x^2+y^2+z^2 exceeds 1.0. s_tready is low while
//  a joint is in work or a result waits; reset clears sequencer, flag, count.
module skeletal_frame_joint_composer_unit
    import sfjc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value_index, frame_value, base_pos_x/y/z, base_orient_x/y/z,
    // anim_flags, start_index, parent_index
    input  logic [223:0] s_tdata,
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    // joint_number, out_pos_x/y/z, out_quat_x/y/z/w
    output logic [175:0] m_tdata,
    output logic [1:0]   m_tuser    // status
);

    // input word fields
    logic [10:0]        in_vidx;
    logic signed [31:0] in_fval;
    logic signed [31:0] in_pos [3];
    logic signed [17:0] in_ori [3];
    logic [5:0]         in_flags;
    logic [10:0]        in_start;
    logic signed [8:0]  in_parent;
    opcode_t            in_op;

    assign in_vidx   = s_tdata[10:0];
    assign in_fval   = s_tdata[42:11];
    assign in_pos[0] = s_tdata[74:43];
    assign in_pos[1] = s_tdata[106:75];
    assign in_pos[2] = s_tdata[138:107];
    assign in_ori[0] = s_tdata[156:139];
    assign in_ori[1] = s_tdata[174:157];
    assign in_ori[2] = s_tdata[192:175];
    assign in_flags  = s_tdata[198:193];
    assign in_start  = s_tdata[209:199];
    assign in_parent = s_tdata[218:210];
    assign in_op     = opcode_t'(s_tuser);

    fsm_t               state_reg;
    logic [CNT_W-1:0]   joint_count_reg;
    logic               out_valid_reg;
    logic [175:0]       out_data_reg;
    logic [1:0]         out_status_reg;

    logic signed [31:0] comp_reg [6];
    logic [5:0]         flags_reg;
    logic [10:0]        start_reg;
    logic               root_reg;
    logic [2:0]         k_reg;
    logic [2:0]         used_reg;

    logic [5:0]         step_reg;
    logic               ph_reg;
    logic signed [69:0] prod_reg;
    logic signed [71:0] acc_reg;

    logic signed [36:0] t_reg [3];
    logic signed [47:0] rpos_reg [3];
    logic signed [55:0] q_reg [4];
    logic signed [32:0] cw_reg;

    logic [63:0]        sq_op_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic               sq_norm_reg;

    logic [1:0]         idx_reg;
    logic [55:0]        mag_reg [4];
    logic [55:0]        m_reg;
    logic [31:0]        n_reg;
    logic [31:0]        div_rem_reg;
    logic [16:0]        div_low_reg;
    logic [16:0]        div_q_reg;
    logic [4:0]         div_cnt_reg;
    logic signed [17:0] nq_reg [4];

    // stores
    logic signed [31:0] fv_mem [MAX_VALUES];
    logic signed [31:0] fv_rd_reg;
    joint_row_t         jm_mem [MAX_JOINTS];
    joint_row_t         jrow_reg;

    logic               s_acc;
    logic               vidx_ok;
    logic [12:0]        slot;
    logic               slot_ok;
    logic               fv_we, fv_re, jm_we, jm_re;
    joint_row_t         jm_wdata;
    logic signed [31:0] pos_sat [3];
    logic signed [17:0] pq [4];

    function automatic logic signed [31:0] jm_pos(input joint_row_t r, input logic [1:0] i);
        case (i)
            2'd0:    jm_pos = r.pos_x;
            2'd1:    jm_pos = r.pos_y;
            default: jm_pos = r.pos_z;
        endcase
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    assign pq[0] = jrow_reg.q_x;
    assign pq[1] = jrow_reg.q_y;
    assign pq[2] = jrow_reg.q_z;
    assign pq[3] = jrow_reg.q_w;

    assign vidx_ok = 13'(in_vidx) < 13'(MAX_VALUES);
    assign slot    = 13'(start_reg) + 13'(used_reg);
    assign slot_ok = slot < 13'(MAX_VALUES);

    assign fv_we = s_acc && (in_op == OP_LOAD) && vidx_ok;
    assign fv_re = (state_reg == S_FETCH) && (k_reg < 3'd6) && flags_reg[k_reg] && slot_ok;
    assign jm_re = s_acc && (in_op == OP_JOINT);
    assign jm_we = (state_reg == S_DONE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (rpos_reg[i] > 48'sd2147483647)
                pos_sat[i] = 32'sh7FFFFFFF;
            else if (rpos_reg[i] < -48'sd2147483648)
                pos_sat[i] = 32'sh80000000;
            else
                pos_sat[i] = rpos_reg[i][31:0];
        end
    end

    assign jm_wdata = '{pos_x: pos_sat[0], pos_y: pos_sat[1], pos_z: pos_sat[2],
                        q_x: nq_reg[0], q_y: nq_reg[1], q_z: nq_reg[2], q_w: nq_reg[3]};

    always_ff @(posedge aclk) begin
        if (fv_we) fv_mem[VAW'(in_vidx)] <= in_fval;
        if (fv_re) fv_rd_reg <= fv_mem[VAW'(slot)];
    end

    always_ff @(posedge aclk) begin
        if (jm_we) jm_mem[JAW'(joint_count_reg)] <= jm_wdata;
        if (jm_re) jrow_reg <= jm_mem[JAW'(in_parent[7:0])];
    end

    // micro-op decode for the multiply-accumulate chain
    logic signed [36:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mac_neg, mac_first, mac_last;
    dest_t              mac_dest;
    logic [1:0]         mac_idx;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mac_neg   = 1'b0;
        mac_first = 1'b0;
        mac_last  = 1'b0;
        mac_dest  = D_SUM;
        mac_idx   = 2'd0;
        case (step_reg)
            // child x^2 + y^2 + z^2
            6'd0: begin mul_a = 37'(comp_reg[3]); mul_b = 33'(comp_reg[3]); mac_first = 1'b1; end
            6'd1: begin mul_a = 37'(comp_reg[4]); mul_b = 33'(comp_reg[4]); end
            6'd2: begin
                mul_a = 37'(comp_reg[5]); mul_b = 33'(comp_reg[5]);
                mac_last = 1'b1; mac_dest = D_SUM;
            end
            // t = 2 * (u x v)
            6'd3: begin mul_a = 37'(comp_reg[2]); mul_b = 33'(pq[1]); mac_first = 1'b1; end
            6'd4: begin
                mul_a = 37'(comp_reg[1]); mul_b = 33'(pq[2]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_T; mac_idx = 2'd0;
            end
            6'd5: begin mul_a = 37'(comp_reg[0]); mul_b = 33'(pq[2]); mac_first = 1'b1; end
            6'd6: begin
                mul_a = 37'(comp_reg[2]); mul_b = 33'(pq[0]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_T; mac_idx = 2'd1;
            end
            6'd7: begin mul_a = 37'(comp_reg[1]); mul_b = 33'(pq[0]); mac_first = 1'b1; end
            6'd8: begin
                mul_a = 37'(comp_reg[0]); mul_b = 33'(pq[1]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_T; mac_idx = 2'd2;
            end
            // w * t
            6'd9: begin
                mul_a = t_reg[0]; mul_b = 33'(pq[3]); mac_first = 1'b1;
                mac_last = 1'b1; mac_dest = D_RA; mac_idx = 2'd0;
            end
            6'd10: begin
                mul_a = t_reg[1]; mul_b = 33'(pq[3]); mac_first = 1'b1;
                mac_last = 1'b1; mac_dest = D_RA; mac_idx = 2'd1;
            end
            6'd11: begin
                mul_a = t_reg[2]; mul_b = 33'(pq[3]); mac_first = 1'b1;
                mac_last = 1'b1; mac_dest = D_RA; mac_idx = 2'd2;
            end
            // u x t
            6'd12: begin mul_a = t_reg[2]; mul_b = 33'(pq[1]); mac_first = 1'b1; end
            6'd13: begin
                mul_a = t_reg[1]; mul_b = 33'(pq[2]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_RB; mac_idx = 2'd0;
            end
            6'd14: begin mul_a = t_reg[0]; mul_b = 33'(pq[2]); mac_first = 1'b1; end
            6'd15: begin
                mul_a = t_reg[2]; mul_b = 33'(pq[0]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_RB; mac_idx = 2'd1;
            end
            6'd16: begin mul_a = t_reg[1]; mul_b = 33'(pq[0]); mac_first = 1'b1; end
            6'd17: begin
                mul_a = t_reg[0]; mul_b = 33'(pq[1]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_RB; mac_idx = 2'd2;
            end
            // Hamilton product parent * child
            6'd18: begin mul_a = 37'(cw_reg); mul_b = 33'(pq[3]); mac_first = 1'b1; end
            6'd19: begin mul_a = 37'(comp_reg[3]); mul_b = 33'(pq[0]); mac_neg = 1'b1; end
            6'd20: begin mul_a = 37'(comp_reg[4]); mul_b = 33'(pq[1]); mac_neg = 1'b1; end
            6'd21: begin
                mul_a = 37'(comp_reg[5]); mul_b = 33'(pq[2]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_Q; mac_idx = 2'd3;
            end
            6'd22: begin mul_a = 37'(comp_reg[3]); mul_b = 33'(pq[3]); mac_first = 1'b1; end
            6'd23: begin mul_a = 37'(cw_reg); mul_b = 33'(pq[0]); end
            6'd24: begin mul_a = 37'(comp_reg[5]); mul_b = 33'(pq[1]); end
            6'd25: begin
                mul_a = 37'(comp_reg[4]); mul_b = 33'(pq[2]); mac_neg = 1'b1;
                mac_last = 1'b1; mac_dest = D_Q; mac_idx = 2'd0;
            end
            6'd26: begin mul_a = 37'(comp_reg[4]); mul_b = 33'(pq[3]); mac_first = 1'b1; end
            6'd27: begin mul_a = 37'(comp_reg[5]); mul_b = 33'(pq[0]); mac_neg = 1'b1; end
            6'd28: begin mul_a = 37'(cw_reg); mul_b = 33'(pq[1]); end
            6'd29: begin
                mul_a = 37'(comp_reg[3]); mul_b = 33'(pq[2]);
                mac_last = 1'b1; mac_dest = D_Q; mac_idx = 2'd1;
            end
            6'd30: begin mul_a = 37'(comp_reg[5]); mul_b = 33'(pq[3]); mac_first = 1'b1; end
            6'd31: begin mul_a = 37'(comp_reg[4]); mul_b = 33'(pq[0]); end
            6'd32: begin mul_a = 37'(comp_reg[3]); mul_b = 33'(pq[1]); mac_neg = 1'b1; end
            6'd33: begin
                mul_a = 37'(cw_reg); mul_b = 33'(pq[2]);
                mac_last = 1'b1; mac_dest = D_Q; mac_idx = 2'd2;
            end
            // sum of squares of the scaled magnitudes
            6'd34: begin
                mul_a = 37'({1'b0, mag_reg[0][29:0]}); mul_b = 33'({1'b0, mag_reg[0][29:0]});
                mac_first = 1'b1;
            end
            6'd35: begin
                mul_a = 37'({1'b0, mag_reg[1][29:0]}); mul_b = 33'({1'b0, mag_reg[1][29:0]});
            end
            6'd36: begin
                mul_a = 37'({1'b0, mag_reg[2][29:0]}); mul_b = 33'({1'b0, mag_reg[2][29:0]});
            end
            6'd37: begin
                mul_a = 37'({1'b0, mag_reg[3][29:0]}); mul_b = 33'({1'b0, mag_reg[3][29:0]});
                mac_last = 1'b1; mac_dest = D_NSUM;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    logic signed [71:0] acc_base, acc_new;
    logic signed [71:0] acc_rnd;    // round half up to Q16.16
    logic signed [71:0] acc_trnd;   // same, of twice the sum
    logic [63:0]        sq_try;
    logic [32:0]        div_r2;
    logic [46:0]        div_dvd;
    logic [55:0]        q_abs;

    assign acc_base = mac_first ? 72'sd0 : acc_reg;
    assign acc_new  = mac_neg ? acc_base - 72'(prod_reg) : acc_base + 72'(prod_reg);
    assign acc_rnd  = (acc_new + 72'sd32768) >>> 16;
    assign acc_trnd = ((acc_new <<< 1) + 72'sd32768) >>> 16;
    assign sq_try   = sq_res_reg + sq_bit_reg;
    assign div_r2   = {div_rem_reg, div_low_reg[16]};
    assign div_dvd  = {1'b0, mag_reg[idx_reg][29:0], 16'd0} + 47'(n_reg >> 1);
    assign q_abs    = q_reg[idx_reg][55] ? 56'(-q_reg[idx_reg]) : 56'(q_reg[idx_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            joint_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        case (in_op)
                            OP_LOAD: begin
                                if (!vidx_ok) begin
                                    out_valid_reg  <= 1'b1;
                                    out_data_reg   <= '0;
                                    out_status_reg <= ST_RANGE;
                                end
                            end
                            OP_FRAME: joint_count_reg <= '0;
                            OP_JOINT: begin
                                if ({1'b0, joint_count_reg} >= (CNT_W+1)'(MAX_JOINTS)) begin
                                    out_valid_reg  <= 1'b1;
                                    out_data_reg   <= '0;
                                    out_status_reg <= ST_RANGE;
                                end else if (!in_parent[8] &&
                                             10'(in_parent[7:0]) >= 10'(joint_count_reg)) begin
                                    out_valid_reg  <= 1'b1;
                                    out_data_reg   <= '0;
                                    out_status_reg <= ST_PARENT;
                                end else begin
                                    for (int i = 0; i < 3; i++) begin
                                        comp_reg[i]     <= in_pos[i];
                                        comp_reg[3 + i] <= 32'(in_ori[i]);
                                    end
                                    flags_reg <= in_flags;
                                    start_reg <= in_start;
                                    root_reg  <= in_parent[8];
                                    k_reg     <= 3'd0;
                                    used_reg  <= 3'd0;
                                    state_reg <= S_FETCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_FETCH: begin
                    if (k_reg == 3'd6) begin
                        step_reg  <= 6'd0;
                        ph_reg    <= 1'b0;
                        state_reg <= S_MAC;
                    end else if (flags_reg[k_reg]) begin
                        if (slot_ok) begin
                            state_reg <= S_FWAIT;
                        end else begin
                            out_valid_reg  <= 1'b1;
                            out_data_reg   <= '0;
                            out_status_reg <= ST_RANGE;
                            state_reg      <= S_IDLE;
                        end
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end

                S_FWAIT: begin
                    comp_reg[k_reg] <= fv_rd_reg;
                    used_reg        <= used_reg + 3'd1;
                    k_reg           <= k_reg + 3'd1;
                    state_reg       <= S_FETCH;
                end

                S_MAC: begin
                    if (!ph_reg) begin
                        prod_reg <= mul_a * mul_b;
                        ph_reg   <= 1'b1;
                    end else begin
                        ph_reg   <= 1'b0;
                        acc_reg  <= acc_new;
                        step_reg <= step_reg + 6'd1;
                        if (mac_last) begin
                            case (mac_dest)
                                D_SUM: begin
                                    if (acc_new > 72'sd4294967296) begin
                                        cw_reg    <= '0;
                                        state_reg <= S_POSTW;
                                    end else begin
                                        sq_op_reg   <= 64'(72'sd4294967296 - acc_new);
                                        sq_res_reg  <= '0;
                                        sq_bit_reg  <= 64'h4000_0000_0000_0000;
                                        sq_norm_reg <= 1'b0;
                                        state_reg   <= S_SQRT;
                                    end
                                end
                                D_T:  t_reg[mac_idx] <= 37'(acc_trnd);
                                D_RA: rpos_reg[mac_idx] <= 48'(comp_reg[mac_idx]) +
                                                           48'(jm_pos(jrow_reg, mac_idx)) +
                                                           48'(acc_rnd);
                                D_RB: rpos_reg[mac_idx] <= rpos_reg[mac_idx] + 48'(acc_rnd);
                                D_Q: begin
                                    q_reg[mac_idx] <= 56'(acc_new);
                                    if (mac_idx == 2'd2) begin
                                        idx_reg   <= 2'd0;
                                        m_reg     <= '0;
                                        state_reg <= S_MAX;
                                    end
                                end
                                D_NSUM: begin
                                    sq_op_reg   <= 64'(acc_new);
                                    sq_res_reg  <= '0;
                                    sq_bit_reg  <= 64'h4000_0000_0000_0000;
                                    sq_norm_reg <= 1'b1;
                                    state_reg   <= S_SQRT;
                                end
                                default: ;
                            endcase
                        end
                    end
                end

                // one result bit per cycle
                S_SQRT: begin
                    if (sq_op_reg >= sq_try) begin
                        sq_op_reg  <= sq_op_reg - sq_try;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == 64'd1) begin
                        if (sq_norm_reg) begin
                            n_reg     <= (sq_op_reg >= sq_try) ?
                                         32'((sq_res_reg >> 1) + sq_bit_reg) :
                                         32'(sq_res_reg >> 1);
                            idx_reg   <= 2'd0;
                            state_reg <= S_DLOAD;
                        end else begin
                            cw_reg    <= (sq_op_reg >= sq_try) ?
                                         -33'((sq_res_reg >> 1) + sq_bit_reg) :
                                         -33'(sq_res_reg >> 1);
                            state_reg <= S_POSTW;
                        end
                    end
                end

                S_POSTW: begin
                    if (root_reg) begin
                        for (int i = 0; i < 3; i++) begin
                            q_reg[i]    <= 56'(comp_reg[3 + i]);
                            rpos_reg[i] <= 48'(comp_reg[i]);
                        end
                        q_reg[3]  <= 56'(cw_reg);
                        idx_reg   <= 2'd0;
                        m_reg     <= '0;
                        state_reg <= S_MAX;
                    end else begin
                        step_reg  <= 6'd3;
                        ph_reg    <= 1'b0;
                        state_reg <= S_MAC;
                    end
                end

                // one magnitude per cycle, running maximum
                S_MAX: begin
                    mag_reg[idx_reg] <= q_abs;
                    if (q_abs > m_reg) m_reg <= q_abs;
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) state_reg <= S_SHIFT;
                end

                // bring the largest magnitude into [2^29, 2^30), one bit a cycle; all zero gives the identity
                S_SHIFT: begin
                    if (m_reg == '0) begin
                        nq_reg[0] <= '0;
                        nq_reg[1] <= '0;
                        nq_reg[2] <= '0;
                        nq_reg[3] <= ONE_Q16;
                        state_reg <= S_DONE;
                    end else if (m_reg >= 56'd1073741824) begin
                        m_reg <= m_reg >> 1;
                        for (int i = 0; i < 4; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (m_reg < 56'd536870912) begin
                        m_reg <= m_reg << 1;
                        for (int i = 0; i < 4; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end else begin
                        step_reg  <= 6'd34;
                        ph_reg    <= 1'b0;
                        state_reg <= S_MAC;
                    end
                end

                // quotient fits 17 bits, so the top of the dividend seeds the remainder
                S_DLOAD: begin
                    div_rem_reg <= 32'(div_dvd[46:17]);
                    div_low_reg <= div_dvd[16:0];
                    div_q_reg   <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end

                S_DIV: begin
                    logic        qb;
                    logic [16:0] qn;
                    qb = div_r2 >= 33'(n_reg);
                    qn = {div_q_reg[15:0], qb};
                    div_rem_reg <= qb ? 32'(div_r2 - 33'(n_reg)) : 32'(div_r2);
                    div_low_reg <= div_low_reg << 1;
                    div_q_reg   <= qn;
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd16) begin
                        nq_reg[idx_reg] <= q_reg[idx_reg][55] ? -18'(qn) : 18'(qn);
                        idx_reg         <= idx_reg + 2'd1;
                        state_reg       <= (idx_reg == 2'd3) ? S_DONE : S_DLOAD;
                    end
                end

                S_DONE: begin
                    out_valid_reg   <= 1'b1;
                    out_status_reg  <= ST_OK;
                    out_data_reg    <= {nq_reg[3], nq_reg[2], nq_reg[1], nq_reg[0],
                                        pos_sat[2], pos_sat[1], pos_sat[0],
                                        8'(joint_count_reg)};
                    joint_count_reg <= joint_count_reg + CNT_W'(1);
                    state_reg       <= S_IDLE;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
